// File: sv/zbl_pkg.sv
// Package for the Z80 branch look-ahead block: opcode constants, the prefix
// scan and decode result types, and the condition helpers.
// No dependencies.
package zbl_pkg;

  localparam int DEF_MAX_PREFIXES = 5;
  localparam int WIN_BYTES        = 8;
  localparam int WIN_W            = 8 * WIN_BYTES;
  localparam int NPFX_W           = 3;

  localparam logic [7:0] OP_PFX_IX   = 8'hDD;
  localparam logic [7:0] OP_PFX_IY   = 8'hFD;
  localparam logic [7:0] OP_PFX_ED   = 8'hED;
  localparam logic [7:0] OP_HALT     = 8'h76;
  localparam logic [7:0] MASK_BLOCK  = 8'hF4;
  localparam logic [7:0] CODE_BLOCK  = 8'hB0;
  localparam logic [7:0] MASK_GRP    = 8'hC7;
  localparam logic [7:0] CODE_RETN   = 8'h45;
  localparam logic [7:0] OP_RET      = 8'hC9;
  localparam logic [7:0] OP_JP       = 8'hC3;
  localparam logic [7:0] OP_CALL     = 8'hCD;
  localparam logic [7:0] MASK_CC     = 8'hC1;
  localparam logic [7:0] CODE_CC     = 8'hC0;
  localparam logic [7:0] CODE_RET_CC = 8'hC0;
  localparam logic [7:0] CODE_CALL_CC = 8'hC4;
  localparam logic [7:0] CODE_JP_CC  = 8'hC2;
  localparam logic [7:0] OP_JP_REG   = 8'hE9;
  localparam logic [7:0] CODE_RST    = 8'hC7;
  localparam logic [7:0] MASK_RST_VEC = 8'h38;
  localparam logic [7:0] CODE_REL    = 8'h00;
  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_EXAF     = 8'h08;
  localparam logic [7:0] OP_JR       = 8'h18;
  localparam logic [7:0] OP_DJNZ     = 8'h10;

  typedef enum logic [1:0] {
    BASE_HL,
    BASE_IX,
    BASE_IY
  } base_sel_t;

  typedef struct packed {
    logic              ovf;
    logic              ext;
    base_sel_t         base_sel;
    logic [NPFX_W-1:0] npfx;
    logic [7:0]        op;
    logic [15:0]       imm;
  } pfx_info_t;

  typedef struct packed {
    logic [15:0] target_addr;
    logic        taken;
    logic        indirect_target;
    logic        is_call;
    logic        is_loop;
    logic        is_block;
  } br_res_t;

  function automatic logic [7:0] cond_mask(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h40;
      2'd1:    m = 8'h01;
      2'd2:    m = 8'h04;
      default: m = 8'h80;
    endcase
    return m;
  endfunction

  function automatic logic cond_true(input logic [7:0] op, input logic [7:0] f,
                                     input logic [1:0] idx);
    logic hit;
    hit = |(f & cond_mask(idx));
    return op[3] ? hit : !hit;
  endfunction

endpackage

// File: sv/zbl_prefix_scan.sv
// Prefix scan: skips leading DD, FD and ED bytes of the code window and
// returns the opcode, immediate word, base register, ED flag, prefix count and overflow flag.
// Depends on zbl_pkg.
module zbl_prefix_scan
  import zbl_pkg::*;
#(
  parameter int MAX_PREFIXES = DEF_MAX_PREFIXES
) (
  input  logic [WIN_W-1:0] code_window,
  output pfx_info_t        info
);

  logic [7:0] cur_byte;
  logic       is_pfx;
  logic       done;

  always_comb begin
    info          = '0;
    info.base_sel = BASE_HL;
    done          = 1'b0;
    cur_byte      = '0;
    is_pfx        = 1'b0;
    for (int k = 0; k <= MAX_PREFIXES; k++) begin
      if (!done && !info.ovf) begin
        cur_byte = code_window[8*k +: 8];
        is_pfx   = 1'b1;
        if (cur_byte == OP_PFX_IX) begin
          info.base_sel = BASE_IX;
        end else if (cur_byte == OP_PFX_IY) begin
          info.base_sel = BASE_IY;
        end else if (cur_byte == OP_PFX_ED) begin
          info.ext = 1'b1;
        end else begin
          is_pfx    = 1'b0;
          done      = 1'b1;
          info.npfx = NPFX_W'(k);
          info.op   = cur_byte;
          info.imm  = code_window[8*(k+1) +: 16];
        end
        if (is_pfx && k == MAX_PREFIXES) begin
          info.ovf = 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/zbl_branch_decode.sv
// Branch decode: from the scanned opcode and the register values, works out
// whether control transfers, the target and the kind of transfer.
// Depends on zbl_pkg.
module zbl_branch_decode
  import zbl_pkg::*;
(
  input  pfx_info_t   info,
  input  logic [15:0] prog_counter,
  input  logic [15:0] stack_word,
  input  logic [15:0] reg_hl,
  input  logic [15:0] reg_ix,
  input  logic [15:0] reg_iy,
  input  logic [7:0]  flag_byte,
  input  logic [7:0]  reg_b,
  output br_res_t     res
);

  logic [7:0]  op;
  logic [15:0] base;
  logic [15:0] rel_tgt;

  assign op = info.op;

  always_comb begin
    case (info.base_sel)
      BASE_IX: base = reg_ix;
      BASE_IY: base = reg_iy;
      default: base = reg_hl;
    endcase
  end

  assign rel_tgt = prog_counter + 16'(info.npfx) + 16'd2
                   + {{8{info.imm[7]}}, info.imm[7:0]};

  always_comb begin
    res = '0;
    if (info.ovf) begin
      res = '0;
    end else if (op == OP_HALT) begin
      res.is_block = 1'b1;
    end else if (info.ext) begin
      if ((op & MASK_BLOCK) == CODE_BLOCK) begin
        res.is_block = 1'b1;
      end else if ((op & MASK_GRP) == CODE_RETN) begin
        res.target_addr     = stack_word;
        res.taken           = 1'b1;
        res.indirect_target = 1'b1;
      end
    end else if (op == OP_RET) begin
      res.target_addr     = stack_word;
      res.taken           = 1'b1;
      res.indirect_target = 1'b1;
    end else if (op == OP_JP) begin
      res.target_addr = info.imm;
      res.taken       = 1'b1;
    end else if (op == OP_CALL) begin
      res.target_addr = info.imm;
      res.taken       = 1'b1;
      res.is_call     = 1'b1;
    end else if ((op & MASK_CC) == CODE_CC) begin
      if (cond_true(op, flag_byte, op[5:4])) begin
        case (op & MASK_GRP)
          CODE_RET_CC: begin
            res.target_addr     = stack_word;
            res.taken           = 1'b1;
            res.indirect_target = 1'b1;
          end
          CODE_CALL_CC: begin
            res.target_addr = info.imm;
            res.taken       = 1'b1;
            res.is_call     = 1'b1;
          end
          CODE_JP_CC: begin
            res.target_addr = info.imm;
            res.taken       = 1'b1;
            res.is_loop     = 1'b1;
          end
          default: res = '0;
        endcase
      end
    end else if (op == OP_JP_REG) begin
      res.target_addr     = base;
      res.taken           = 1'b1;
      res.indirect_target = 1'b1;
    end else if ((op & MASK_GRP) == CODE_RST) begin
      res.target_addr = {8'h00, op & MASK_RST_VEC};
      res.taken       = 1'b1;
      res.is_call     = 1'b1;
    end else if ((op & MASK_GRP) == CODE_REL && op != OP_NOP && op != OP_EXAF) begin
      if (op == OP_JR) begin
        res.target_addr = rel_tgt;
        res.taken       = 1'b1;
      end else if (op == OP_DJNZ) begin
        if (reg_b != 8'd1) begin
          res.target_addr = rel_tgt;
          res.taken       = 1'b1;
          res.is_loop     = 1'b1;
        end
      end else if (cond_true(op, flag_byte, {1'b0, op[4]})) begin
        res.target_addr = rel_tgt;
        res.taken       = 1'b1;
        res.is_loop     = 1'b1;
      end
    end
  end

endmodule

// File: sv/z80_branch_lookahead.sv
// Top level of the Z80 branch look-ahead: input register, prefix scan and
// decode, result register. Depends on zbl_pkg, zbl_prefix_scan, zbl_branch_decode.
//
//  channel | direction | ports
//  --------+-----------+--------------------------------------------------
//  in_     | input     | code_window, prog_counter, stack_word, regs, F, B
//  out_    | output    | target_addr, taken, indirect_target, kind flags
//
// One transaction is accepted per cycle while in_ready is high. The
// input register loads on acceptance; the result register loads the
// decode of that item once it has room or is being drained.
// Reset clears only the two valid flags.
// A stalled result holds the result register; the input register keeps
// accepting while it is empty or the result register has room or is being drained.
module z80_branch_lookahead
  import zbl_pkg::*;
#(
  parameter int MAX_PREFIXES = DEF_MAX_PREFIXES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIN_W-1:0] in_code_window,
  input  logic [15:0]      in_prog_counter,
  input  logic [15:0]      in_stack_word,
  input  logic [15:0]      in_reg_hl,
  input  logic [15:0]      in_reg_ix,
  input  logic [15:0]      in_reg_iy,
  input  logic [7:0]       in_flag_byte,
  input  logic [7:0]       in_reg_b,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      out_target_addr,
  output logic             out_taken,
  output logic             out_indirect_target,
  output logic             out_is_call,
  output logic             out_is_loop,
  output logic             out_is_block
);

  logic             s1_valid_r, s1_valid_nxt;
  logic [WIN_W-1:0] win_r;
  logic [15:0]      pc_r, sw_r, hl_r, ix_r, iy_r;
  logic [7:0]       f_r, b_r;
  logic             out_valid_r, out_valid_nxt;
  br_res_t          res_r;
  br_res_t          res_nxt;
  pfx_info_t        info;
  logic             s2_load;
  logic             s1_load;

  assign s2_load  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_load;
  assign s1_load  = in_valid && in_ready;

  assign s1_valid_nxt  = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s2_load ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      win_r <= in_code_window;
      pc_r  <= in_prog_counter;
      sw_r  <= in_stack_word;
      hl_r  <= in_reg_hl;
      ix_r  <= in_reg_ix;
      iy_r  <= in_reg_iy;
      f_r   <= in_flag_byte;
      b_r   <= in_reg_b;
    end
    if (s2_load && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  zbl_prefix_scan #(
    .MAX_PREFIXES(MAX_PREFIXES)
  ) u_scan (
    .code_window(win_r),
    .info       (info)
  );

  zbl_branch_decode u_decode (
    .info        (info),
    .prog_counter(pc_r),
    .stack_word  (sw_r),
    .reg_hl      (hl_r),
    .reg_ix      (ix_r),
    .reg_iy      (iy_r),
    .flag_byte   (f_r),
    .reg_b       (b_r),
    .res         (res_nxt)
  );

  assign out_valid           = out_valid_r;
  assign out_target_addr     = res_r.target_addr;
  assign out_taken           = res_r.taken;
  assign out_indirect_target = res_r.indirect_target;
  assign out_is_call         = res_r.is_call;
  assign out_is_loop         = res_r.is_loop;
  assign out_is_block        = res_r.is_block;

  a_untaken_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_taken |-> out_target_addr == 16'd0)
    else $error("untaken result carries a nonzero target");

  a_block_untaken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_block |-> !out_taken && !out_is_call && !out_is_loop)
    else $error("block result marked as a transfer");

  a_kind_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_is_call || out_is_loop || out_indirect_target) |-> out_taken)
    else $error("transfer kind set without taken");

  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_load |=> out_valid)
    else $error("input register item did not reach the result register");

endmodule

// File: dv/lookahead_sb_pkg.sv
`timescale 1ns / 100ps
// Instruction transaction type and scoreboard for the Z80 branch look-ahead.
// Holds the branch outcome predictor and the queue of outcomes still due.
// Depends on zbl_pkg for the result type and the opcode constants.
package lookahead_sb_pkg;
  import zbl_pkg::*;

  localparam int MAX_PFX = DEF_MAX_PREFIXES;

  localparam logic [7:0] FLAG_S  = 8'h80;
  localparam logic [7:0] FLAG_Z  = 8'h40;
  localparam logic [7:0] FLAG_PV = 8'h04;
  localparam logic [7:0] FLAG_C  = 8'h01;

  typedef struct packed {
    logic [WIN_W-1:0] code_window;
    logic [15:0]      prog_counter;
    logic [15:0]      stack_word;
    logic [15:0]      reg_hl;
    logic [15:0]      reg_ix;
    logic [15:0]      reg_iy;
    logic [7:0]       flag_byte;
    logic [7:0]       reg_b;
  } lookahead_req_t;

  class lookahead_scoreboard;
    br_res_t outcomes_due[$];
    int n_checked;
    int n_mismatch;
    int n_taken;
    int n_indirect;
    int n_calls;
    int n_loops;
    int n_blocks;

    function bit cond_holds(logic [7:0] op, logic [7:0] f, logic [1:0] sel);
      logic [7:0] m;
      case (sel)
        2'd0:    m = FLAG_Z;
        2'd1:    m = FLAG_C;
        2'd2:    m = FLAG_PV;
        default: m = FLAG_S;
      endcase
      return op[3] ? |(f & m) : ~|(f & m);
    endfunction

    function br_res_t taken_to(logic [15:0] tgt, bit ind, bit call, bit loop);
      br_res_t res;
      res = '0;
      res.target_addr = tgt;
      res.taken = 1'b1;
      res.indirect_target = ind;
      res.is_call = call;
      res.is_loop = loop;
      return res;
    endfunction

    function br_res_t predict_outcome(lookahead_req_t r);
      br_res_t res;
      logic [7:0] op;
      logic [7:0] disp;
      logic [15:0] base;
      logic [15:0] imm;
      logic [15:0] next_pc;
      logic [15:0] rel_tgt;
      bit ext;
      int unsigned n;
      res = '0;
      base = r.reg_hl;
      ext = 1'b0;
      n = 0;
      op = r.code_window[7:0];
      while (op == OP_PFX_IX || op == OP_PFX_IY || op == OP_PFX_ED) begin
        if (op == OP_PFX_IX) base = r.reg_ix;
        else if (op == OP_PFX_IY) base = r.reg_iy;
        else ext = 1'b1;
        if (n >= MAX_PFX) return res;
        n++;
        op = r.code_window[8*n +: 8];
      end
      disp = r.code_window[8*(n+1) +: 8];
      imm = {r.code_window[8*(n+2) +: 8], disp};
      next_pc = r.prog_counter + 16'd2 + n[15:0];
      rel_tgt = next_pc + {{8{disp[7]}}, disp};

      if (op == OP_HALT) begin
        res.is_block = 1'b1;
        return res;
      end
      if (ext) begin
        if ((op & MASK_BLOCK) == CODE_BLOCK) res.is_block = 1'b1;
        else if ((op & MASK_GRP) == CODE_RETN)
          res = taken_to(r.stack_word, 1'b1, 1'b0, 1'b0);
        return res;
      end
      if (op == OP_RET) return taken_to(r.stack_word, 1'b1, 1'b0, 1'b0);
      if (op == OP_JP) return taken_to(imm, 1'b0, 1'b0, 1'b0);
      if (op == OP_CALL) return taken_to(imm, 1'b0, 1'b1, 1'b0);
      if ((op & MASK_CC) == CODE_CC) begin
        if (!cond_holds(op, r.flag_byte, op[5:4])) return res;
        if ((op & MASK_GRP) == CODE_RET_CC)
          return taken_to(r.stack_word, 1'b1, 1'b0, 1'b0);
        if ((op & MASK_GRP) == CODE_CALL_CC) return taken_to(imm, 1'b0, 1'b1, 1'b0);
        if ((op & MASK_GRP) == CODE_JP_CC) return taken_to(imm, 1'b0, 1'b0, 1'b1);
      end
      if (op == OP_JP_REG) return taken_to(base, 1'b1, 1'b0, 1'b0);
      if ((op & MASK_GRP) == CODE_RST)
        return taken_to({8'h00, op & MASK_RST_VEC}, 1'b0, 1'b1, 1'b0);
      if ((op & MASK_GRP) == CODE_REL && op != OP_NOP && op != OP_EXAF) begin
        if (op == OP_JR) return taken_to(rel_tgt, 1'b0, 1'b0, 1'b0);
        if (op == OP_DJNZ)
          return (r.reg_b == 8'd1) ? res : taken_to(rel_tgt, 1'b0, 1'b0, 1'b1);
        if (cond_holds(op, r.flag_byte, {1'b0, op[4]}))
          return taken_to(rel_tgt, 1'b0, 1'b0, 1'b1);
      end
      return res;
    endfunction

    function void note_instruction(lookahead_req_t r);
      outcomes_due.push_back(predict_outcome(r));
    endfunction

    function void check_result(br_res_t got);
      br_res_t want;
      if (outcomes_due.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("Unexpected result transaction: tgt=%h tk=%b ind=%b call=%b loop=%b blk=%b",
                   got.target_addr, got.taken, got.indirect_target, got.is_call,
                   got.is_loop, got.is_block);
        return;
      end
      want = outcomes_due.pop_front();
      n_checked++;
      if (got.target_addr !== want.target_addr || got.taken !== want.taken ||
          got.indirect_target !== want.indirect_target || got.is_call !== want.is_call ||
          got.is_loop !== want.is_loop || got.is_block !== want.is_block) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("Mismatch on result %0d:", n_checked);
          $display("  expected tgt=%h tk=%b ind=%b call=%b loop=%b blk=%b",
                   want.target_addr, want.taken, want.indirect_target, want.is_call,
                   want.is_loop, want.is_block);
          $display("  actual   tgt=%h tk=%b ind=%b call=%b loop=%b blk=%b",
                   got.target_addr, got.taken, got.indirect_target, got.is_call,
                   got.is_loop, got.is_block);
        end
      end
      n_taken += want.taken;
      n_indirect += want.indirect_target;
      n_calls += want.is_call;
      n_loops += want.is_loop;
      n_blocks += want.is_block;
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction
  endclass

endpackage

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench for z80_branch_lookahead: directed and random instruction
// transactions with random idling on both channels, checked against a scoreboard.
// Depends on zbl_pkg, lookahead_sb_pkg and the block's RTL.
module tb_top;
  import zbl_pkg::*;
  import lookahead_sb_pkg::*;

  localparam int N_RANDOM     = 850;
  localparam int TAIL_ITEMS   = 100;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [7:0] OP_RET_Z   = 8'hC8;
  localparam logic [7:0] OP_CALL_NC = 8'hD4;
  localparam logic [7:0] OP_JP_PE   = 8'hEA;
  localparam logic [7:0] OP_JR_NZ   = 8'h20;
  localparam logic [7:0] OP_JR_C    = 8'h38;
  localparam logic [7:0] OP_RETI    = 8'h4D;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic out_valid;
  logic out_ready;
  logic [15:0] out_target_addr;
  logic out_taken;
  logic out_indirect_target;
  logic out_is_call;
  logic out_is_loop;
  logic out_is_block;
  lookahead_req_t req;
  lookahead_scoreboard sb;
  bit quiet_tail;
  int cycle_count;
  int n_sent;
  int n_directed;

  z80_branch_lookahead uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_code_window      (req.code_window),
    .in_prog_counter     (req.prog_counter),
    .in_stack_word       (req.stack_word),
    .in_reg_hl           (req.reg_hl),
    .in_reg_ix           (req.reg_ix),
    .in_reg_iy           (req.reg_iy),
    .in_flag_byte        (req.flag_byte),
    .in_reg_b            (req.reg_b),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_target_addr     (out_target_addr),
    .out_taken           (out_taken),
    .out_indirect_target (out_indirect_target),
    .out_is_call         (out_is_call),
    .out_is_loop         (out_is_loop),
    .out_is_block        (out_is_block)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_instruction(req);
      if (out_valid && out_ready)
        sb.check_result({out_target_addr, out_taken, out_indirect_target,
                         out_is_call, out_is_loop, out_is_block});
    end
  end

  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (quiet_tail) out_ready = 1'b1;
      else begin
        case ($urandom_range(0, 9))
          0, 1: begin
            out_ready = 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clk);
          end
          2: begin
            out_ready = 1'b1;
            repeat ($urandom_range(20, 60)) @(negedge clk);
          end
          default: out_ready = 1'b1;
        endcase
      end
    end
  end

  task automatic send(input lookahead_req_t r);
    @(negedge clk);
    req = r;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_instr(input logic [63:0] win, input logic [15:0] pc,
                            input logic [7:0] f, input logic [7:0] b);
    lookahead_req_t r;
    r.code_window = win;
    r.prog_counter = pc;
    r.stack_word = 16'($urandom);
    r.reg_hl = 16'($urandom);
    r.reg_ix = 16'($urandom);
    r.reg_iy = 16'($urandom);
    r.flag_byte = f;
    r.reg_b = b;
    send(r);
  endtask

  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_prefix();
    if ($urandom_range(0, 7) == 0) return OP_PFX_ED;
    return $urandom_range(0, 1) ? OP_PFX_IX : OP_PFX_IY;
  endfunction

  function automatic lookahead_req_t random_req();
    lookahead_req_t r;
    logic [7:0] bytes [8];
    logic [7:0] rnd;
    logic [7:0] op;
    int kind;
    int npfx;
    int sel;
    for (int k = 0; k < 8; k++) bytes[k] = 8'($urandom);
    rnd = 8'($urandom);
    kind = $urandom_range(0, 9);
    if (kind != 0) begin
      sel = $urandom_range(0, 15);
      if (sel <= 8) npfx = 0;
      else if (sel <= 11) npfx = 1;
      else if (sel == 12) npfx = 2;
      else if (sel == 13) npfx = $urandom_range(3, 4);
      else if (sel == 14) npfx = MAX_PFX;
      else npfx = MAX_PFX + 1;
      for (int k = 0; k < npfx; k++) bytes[k] = random_prefix();
      if (kind == 1) begin
        if (npfx == 0) npfx = 1;
        if (npfx <= MAX_PFX + 1) bytes[npfx-1] = OP_PFX_ED;
        case ($urandom_range(0, 4))
          0:       op = CODE_BLOCK | (rnd & 8'h0B);
          1:       op = CODE_RETN | (rnd & MASK_RST_VEC);
          2:       op = OP_HALT;
          default: op = rnd;
        endcase
      end else begin
        case ($urandom_range(0, 7))
          0:       op = rnd;
          1:       op = {2'b11, rnd[5:0]};
          2, 6:    op = {2'b00, rnd[5:3], 3'b000};
          4:       op = {2'b11, rnd[5:3], 3'b111};
          5:       op = {2'b11, rnd[5:1], 1'b0};
          default: begin
            case (rnd[1:0])
              2'd0:    op = OP_JP;
              2'd1:    op = OP_CALL;
              2'd2:    op = OP_RET;
              default: op = OP_JP_REG;
            endcase
          end
        endcase
      end
      if (npfx <= MAX_PFX) bytes[npfx] = op;
    end
    for (int k = 0; k < 8; k++) r.code_window[8*k +: 8] = bytes[k];
    if ($urandom_range(0, 7) == 0)
      r.prog_counter = $urandom_range(0, 1) ? 16'hFFF8 + 16'($urandom_range(0, 7))
                                            : 16'($urandom_range(0, 7));
    else
      r.prog_counter = 16'($urandom);
    r.stack_word = 16'($urandom);
    r.reg_hl = 16'($urandom);
    r.reg_ix = 16'($urandom);
    r.reg_iy = 16'($urandom);
    r.flag_byte = 8'($urandom);
    r.reg_b = ($urandom_range(0, 5) == 0) ? 8'd1 : 8'($urandom);
    return r;
  endfunction

  task automatic run_directed();
    lookahead_req_t r;
    r = '0;
    send(r);
    r = '1;
    send(r);
    send_instr({40'h0, 8'hA5, 8'h5A, OP_JP}, 16'h1234, 8'h00, 8'h05);
    send_instr({40'h0, 8'hFF, 8'hFF, OP_CALL}, 16'hFFFF, 8'hFF, 8'h05);
    send_instr({56'h0, OP_RET}, 16'h0100, 8'h00, 8'h05);
    send_instr({56'h0, OP_RET_Z}, 16'h0100, FLAG_Z, 8'h05);
    send_instr({56'h0, CODE_RET_CC}, 16'h0100, FLAG_Z, 8'h05);
    send_instr({40'h0, 8'h80, 8'h00, OP_CALL_NC}, 16'h4000, 8'h00, 8'h05);
    send_instr({40'h0, 8'h12, 8'h34, OP_JP_PE}, 16'h4000, FLAG_PV, 8'h05);
    send_instr({56'h0, OP_JP_REG}, 16'h2000, 8'h00, 8'h05);
    send_instr({48'h0, OP_JP_REG, OP_PFX_IX}, 16'h2000, 8'h00, 8'h05);
    send_instr({40'h0, OP_JP_REG, OP_PFX_IY, OP_PFX_IX}, 16'h2000, 8'h00, 8'h05);
    send_instr({48'h0, 8'h80, OP_JR}, 16'h0001, 8'h00, 8'h05);
    send_instr({48'h0, 8'h7F, OP_JR}, 16'hFFFE, 8'h00, 8'h05);
    send_instr({48'h0, 8'hFE, OP_DJNZ}, 16'h8000, 8'h00, 8'h01);
    send_instr({48'h0, 8'hFE, OP_DJNZ}, 16'h8000, 8'h00, 8'h00);
    send_instr({48'h0, 8'h10, OP_JR_NZ}, 16'h8000, 8'h00, 8'h05);
    send_instr({48'h0, 8'h10, OP_JR_C}, 16'h8000, 8'h00, 8'h05);
    send_instr({56'h0, OP_HALT}, 16'h0038, 8'h00, 8'h05);
    send_instr({48'h0, OP_HALT, OP_PFX_ED}, 16'h0038, 8'h00, 8'h05);
    send_instr({48'h0, CODE_BLOCK, OP_PFX_ED}, 16'h0038, 8'h00, 8'h05);
    send_instr({48'h0, CODE_RETN, OP_PFX_ED}, 16'h0066, 8'h00, 8'h05);
    send_instr({48'h0, OP_RETI, OP_PFX_ED}, 16'h0066, 8'h00, 8'h05);
    send_instr({48'h0, OP_RET, OP_PFX_ED}, 16'h0066, 8'h00, 8'h05);
    send_instr({8'h12, OP_JP, {6{OP_PFX_IX}}}, 16'h3000, 8'h00, 8'h05);
    send_instr({16'h0, OP_JP_REG, OP_PFX_IY, OP_PFX_IX, OP_PFX_IY, OP_PFX_IX, OP_PFX_IX},
               16'h3000, 8'h00, 8'h05);
    send_instr({8'h00, 8'hF0, OP_JR, OP_PFX_IY, OP_PFX_IX, OP_PFX_IY, OP_PFX_IX, OP_PFX_IX},
               16'hFFFC, 8'h00, 8'h05);
  endtask

  initial begin
    sb = new;
    req = '0;
    in_valid = 1'b0;
    rst_n = 1'b0;
    quiet_tail = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    n_directed = n_sent;
    wait_for_drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) wait_for_drain();
      if (i == N_RANDOM - TAIL_ITEMS) quiet_tail = 1'b1;
      if (!quiet_tail && $urandom_range(0, 5) == 0) idle_for($urandom_range(1, 12));
      send(random_req());
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d instruction transactions (%0d directed) with idling, back-pressure,",
             n_sent, n_directed);
    $display("a full drain mid-run and a full-rate tail; %0d taken, %0d indirect, %0d calls,",
             sb.n_taken, sb.n_indirect, sb.n_calls);
    $display("%0d loops, %0d halt/block, %0d mismatches.",
             sb.n_loops, sb.n_blocks, sb.n_mismatch);
    if (sb.n_mismatch == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
sv/zbl_pkg.sv
sv/zbl_prefix_scan.sv
sv/zbl_branch_decode.sv
sv/z80_branch_lookahead.sv
dv/lookahead_sb_pkg.sv
dv/tb_top.sv
